### hw/rtl/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher core.
`default_nettype none
package rc4_pkg;

	localparam int BYTE_W     = 8;
	localparam int SBOX_DEPTH = 256;

	// Request kinds
	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] key_byte;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
	} rc4_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic              last_out;
	} rc4_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/rc4_ram.sv
// Generic simple dual-port RAM with registered read, used for all state stores.
`default_nettype none
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic                                         re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port: data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/rc4_stream_cipher_core.sv
// Top level of the RC4 stream cipher core: key store, key schedule and keystream sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  req     | in        | req_valid / req_ready  | kind, key_byte, data_byte, last
//  rsp     | out       | rsp_valid / rsp_ready  | data_out, last_out (one per data request)
//
// A key request leaves the core idle. A data request on a keyed box runs: S[i] read,
// S[j] read, two write-backs of the swap (the S[t] read issued with the second), result.
// The first data request of a message adds an identity fill, one schedule step per entry
// (read, accumulate, two write-backs), all set by the single write port of the S-box RAM.
// Reset clears control state only; the RAMs need no clearing pass, since the schedule
// fills the S-box before any read and only written key entries are read.
// A stalled result waits in the output register while the next request is taken; a
// further data result then waits in its final state until the register frees.
`default_nettype none
module rc4_stream_cipher_core #(
	parameter int MAX_KEY_BYTES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire rc4_pkg::rc4_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rc4_pkg::rc4_rsp_t      rsp
);
	import rc4_pkg::*;

	localparam int KA = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int LW = $clog2(MAX_KEY_BYTES + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_INIT   = 4'd1;
	localparam logic [3:0] ST_KS_RD  = 4'd2;
	localparam logic [3:0] ST_KS_ACC = 4'd3;
	localparam logic [3:0] ST_KS_W1  = 4'd4;
	localparam logic [3:0] ST_KS_W2  = 4'd5;
	localparam logic [3:0] ST_P_RDI  = 4'd6;
	localparam logic [3:0] ST_P_RDJ  = 4'd7;
	localparam logic [3:0] ST_P_W1   = 4'd8;
	localparam logic [3:0] ST_P_W2   = 4'd9;
	localparam logic [3:0] ST_P_OUT  = 4'd10;

	logic [3:0]        state_q;
	logic [BYTE_W-1:0] cnt_q;
	logic [BYTE_W-1:0] acc_q;
	logic [KA-1:0]     kpos_q;
	logic [LW-1:0]     key_len_q;
	logic              loading_q;
	logic              keyed_q;
	logic [BYTE_W-1:0] idx_i_q;
	logic [BYTE_W-1:0] idx_j_q;
	logic [BYTE_W-1:0] si_q;
	logic [BYTE_W-1:0] sj_q;
	logic [BYTE_W-1:0] data_q;
	logic              last_q;
	logic              fwd_hit_q;
	logic              rsp_valid_q;
	rc4_rsp_t          rsp_q;

	// S-box RAM controls
	logic              sbox_we;
	logic [BYTE_W-1:0] sbox_waddr;
	logic [BYTE_W-1:0] sbox_wdata;
	logic              sbox_re;
	logic [BYTE_W-1:0] sbox_raddr;
	logic [BYTE_W-1:0] sbox_rdata;

	// Key RAM controls
	logic              key_we;
	logic [KA-1:0]     key_waddr;
	logic              key_re;
	logic [BYTE_W-1:0] key_rdata;

	logic              req_fire;
	logic [LW-1:0]     eff_len;
	logic [BYTE_W-1:0] key_b;
	logic [BYTE_W-1:0] acc_new;
	logic [BYTE_W-1:0] idx_i_inc;
	logic [BYTE_W-1:0] idx_j_new;
	logic [BYTE_W-1:0] t_addr;
	logic [BYTE_W-1:0] ks_byte;
	logic              rsp_load;
	logic [KA-1:0]     kpos_inc;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Key store length before a key byte is written: a fresh key starts from empty
	assign eff_len   = loading_q ? key_len_q : '0;
	assign key_we    = req_fire && (req.kind == KIND_KEY) && (eff_len < LW'(MAX_KEY_BYTES));
	assign key_waddr = eff_len[KA-1:0];
	assign key_re    = (state_q == ST_KS_RD);
	assign kpos_inc  = kpos_q + KA'(1);

	// Schedule arithmetic; an empty key acts as one zero byte
	assign key_b     = (key_len_q == '0) ? '0 : key_rdata;
	assign acc_new   = acc_q + sbox_rdata + key_b;
	assign idx_i_inc = idx_i_q + 8'd1;
	assign idx_j_new = idx_j_q + sbox_rdata;
	assign t_addr    = si_q + sj_q;
	assign ks_byte   = fwd_hit_q ? si_q : sbox_rdata;
	assign rsp_load  = (state_q == ST_P_OUT) && (!rsp_valid_q || rsp_ready);

	// Steer S-box reads and writes per sequencer state
	always_comb begin
		sbox_we    = 1'b0;
		sbox_waddr = '0;
		sbox_wdata = '0;
		sbox_re    = 1'b0;
		sbox_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				sbox_re    = req_fire && (req.kind == KIND_DATA) && keyed_q;
				sbox_raddr = idx_i_inc;
			end
			ST_INIT: begin
				sbox_we    = 1'b1;
				sbox_waddr = cnt_q;
				sbox_wdata = cnt_q;
			end
			ST_KS_RD: begin
				sbox_re    = 1'b1;
				sbox_raddr = cnt_q;
			end
			ST_KS_ACC: begin
				sbox_re    = 1'b1;
				sbox_raddr = acc_new;
			end
			ST_KS_W1: begin
				sbox_we    = 1'b1;
				sbox_waddr = cnt_q;
				sbox_wdata = sbox_rdata;
			end
			ST_KS_W2: begin
				sbox_we    = 1'b1;
				sbox_waddr = acc_q;
				sbox_wdata = si_q;
			end
			ST_P_RDI: begin
				sbox_re    = 1'b1;
				sbox_raddr = idx_i_inc;
			end
			ST_P_RDJ: begin
				sbox_re    = 1'b1;
				sbox_raddr = idx_j_new;
			end
			ST_P_W1: begin
				sbox_we    = 1'b1;
				sbox_waddr = idx_i_q;
				sbox_wdata = sbox_rdata;
			end
			ST_P_W2: begin
				sbox_we    = 1'b1;
				sbox_waddr = idx_j_q;
				sbox_wdata = si_q;
				sbox_re    = 1'b1;
				sbox_raddr = t_addr;
			end
			default: begin
				sbox_we = 1'b0;
			end
		endcase
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			acc_q       <= '0;
			kpos_q      <= '0;
			key_len_q   <= '0;
			loading_q   <= 1'b0;
			keyed_q     <= 1'b0;
			idx_i_q     <= '0;
			idx_j_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Release the output register once taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.kind == KIND_KEY) begin
							key_len_q <= key_we ? (eff_len + LW'(1)) : eff_len;
							loading_q <= !req.last;
							keyed_q   <= 1'b0;
						end else begin
							loading_q <= 1'b0;
							if (keyed_q) begin
								idx_i_q <= idx_i_inc;
								state_q <= ST_P_RDJ;
							end else begin
								cnt_q   <= '0;
								state_q <= ST_INIT;
							end
						end
					end
				end
				ST_INIT: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'(SBOX_DEPTH - 1)) begin
						acc_q   <= '0;
						kpos_q  <= '0;
						state_q <= ST_KS_RD;
					end
				end
				ST_KS_RD: begin
					// Advance the key position, wrapping at the key length
					kpos_q  <= ((LW'(kpos_q) + LW'(1)) == key_len_q) ? '0 : kpos_inc;
					state_q <= ST_KS_ACC;
				end
				ST_KS_ACC: begin
					acc_q   <= acc_new;
					state_q <= ST_KS_W1;
				end
				ST_KS_W1: begin
					state_q <= ST_KS_W2;
				end
				ST_KS_W2: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'(SBOX_DEPTH - 1)) begin
						keyed_q <= 1'b1;
						idx_i_q <= '0;
						idx_j_q <= '0;
						state_q <= ST_P_RDI;
					end else begin
						state_q <= ST_KS_RD;
					end
				end
				ST_P_RDI: begin
					idx_i_q <= idx_i_inc;
					state_q <= ST_P_RDJ;
				end
				ST_P_RDJ: begin
					idx_j_q <= idx_j_new;
					state_q <= ST_P_W1;
				end
				ST_P_W1: begin
					state_q <= ST_P_W2;
				end
				ST_P_W2: begin
					state_q <= ST_P_OUT;
				end
				ST_P_OUT: begin
					if (rsp_load) begin
						if (last_q) begin
							keyed_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			data_q <= req.data_byte;
			last_q <= req.last;
		end
		// Hold S[n] for the schedule swap and S[i] for the keystream swap
		if ((state_q == ST_KS_ACC) || (state_q == ST_P_RDJ)) begin
			si_q <= sbox_rdata;
		end
		if (state_q == ST_P_W1) begin
			sj_q <= sbox_rdata;
		end
		// The S[t] read shares a cycle with the S[j] write: forward on a match
		if (state_q == ST_P_W2) begin
			fwd_hit_q <= (t_addr == idx_j_q);
		end
		if (rsp_load) begin
			rsp_q.data_out <= data_q ^ ks_byte;
			rsp_q.last_out <= last_q;
		end
	end

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SBOX_DEPTH)
	) u_sbox_ram (
		.clk   (clk),
		.we    (sbox_we),
		.waddr (sbox_waddr),
		.wdata (sbox_wdata),
		.re    (sbox_re),
		.raddr (sbox_raddr),
		.rdata (sbox_rdata)
	);

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_KEY_BYTES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (req.key_byte),
		.re    (key_re),
		.raddr (kpos_q),
		.rdata (key_rdata)
	);

	// The S-box is never written while waiting for a request
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sbox_we)
		else $error("S-box written while idle");

	// The box only becomes keyed at the end of the schedule
	a_keyed_from_schedule: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(keyed_q) |-> ($past(state_q) == ST_KS_W2))
		else $error("keyed set outside the schedule");

	// Key length stays within the key store
	a_key_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_len_q <= LW'(MAX_KEY_BYTES))
		else $error("key length beyond key store");

	// Any key byte forces a rekey before the next data byte
	a_key_clears_keyed: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.kind == KIND_KEY)) |=> !keyed_q)
		else $error("key byte did not clear keyed");

endmodule
`default_nettype wire
